[rtl/xs64_pkg.sv]
// ----------------------------------------------------------------------------
// xs64_pkg: shared types and constants of the xorshift64 random source.
// Request and response beats, request kinds, sequencer states, word update.
// ----------------------------------------------------------------------------
package xs64_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned BOUND_W = 31;
  localparam int unsigned CNT_W   = $clog2(WORD_W);

  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 7;
  localparam int unsigned SHIFT_C = 17;

  localparam logic [WORD_W-1:0]  DEFAULT_WORD = 64'd12345;
  localparam logic [WORD_W-1:0]  FRAC_MASK    = 64'h0000_0000_7FFF_FFFF;

  localparam logic [1:0] FUNC_RAW  = 2'd0;
  localparam logic [1:0] FUNC_MOD  = 2'd1;
  localparam logic [1:0] FUNC_FRAC = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [BOUND_W-1:0] bound;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              bad_bound;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] w_in);
    logic [WORD_W-1:0] w;
    w = w_in;
    w = w ^ (w << SHIFT_A);
    w = w ^ (w >> SHIFT_B);
    w = w ^ (w << SHIFT_C);
    return w;
  endfunction

endpackage

[rtl/xorshift64_random_source_unit.sv]
// ----------------------------------------------------------------------------
// xorshift64_random_source_unit: xorshift64 source with raw, integer and fraction beats.
// Raw, fraction: response registered on accept; one beat a cycle unless stalled.
// Integer: ST_DIV forms the remainder, ST_HOLD sends it; no new request till then.
// Synchronous reset loads the generator word with 12345 and empties the output.
// ----------------------------------------------------------------------------
module xorshift64_random_source_unit
  import xs64_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_write,
  input  logic [WORD_W-1:0] seed,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp
);

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [WORD_W-1:0]   word, word_next;
  logic [WORD_W-1:0]   shreg, shreg_next;
  logic [BOUND_W-1:0]  rem, rem_next;
  logic [BOUND_W-1:0]  bnd, bnd_next;
  logic                rsp_valid_next;
  rsp_t                rsp_next;

  logic                out_free;
  logic                accept;
  logic [WORD_W-1:0]   adv;
  logic [BOUND_W:0]    rem_sh;
  logic                ge;
  logic [BOUND_W-1:0]  diff;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !out_free || seed_write;
  assign accept    = req_valid && !req_stall;
  assign adv       = xs_advance(word);

  assign rem_sh = {rem, shreg[WORD_W-1]};
  assign ge     = rem_sh >= {1'b0, bnd};
  assign diff   = rem_sh[BOUND_W-1:0] - bnd;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    word_next      = word;
    shreg_next     = shreg;
    rem_next       = rem;
    bnd_next       = bnd;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          word_next = adv;
          if (req.func == FUNC_MOD && req.bound != '0) begin
            shreg_next = adv;
            rem_next   = '0;
            bnd_next   = req.bound;
            cnt_next   = '0;
            state_next = ST_DIV;
          end else begin
            rsp_valid_next     = 1'b1;
            rsp_next.bad_bound = (req.func == FUNC_MOD);
            case (req.func)
              FUNC_RAW:  rsp_next.value = adv;
              FUNC_FRAC: rsp_next.value = adv & FRAC_MASK;
              default:   rsp_next.value = '0;
            endcase
          end
        end
      end
      ST_DIV: begin
        shreg_next = {shreg[WORD_W-2:0], 1'b0};
        rem_next   = ge ? diff : rem_sh[BOUND_W-1:0];
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          rsp_valid_next     = 1'b1;
          rsp_next.value     = {{(WORD_W-BOUND_W){1'b0}}, rem};
          rsp_next.bad_bound = 1'b0;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (seed_write) begin
      word_next = (seed != '0) ? seed : DEFAULT_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      word      <= DEFAULT_WORD;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      word      <= word_next;
      rsp_valid <= rsp_valid_next;
      cnt       <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    rem   <= rem_next;
    bnd   <= bnd_next;
    rsp   <= rsp_next;
  end

`ifndef SYNTHESIS
  a_word_nonzero: assert property (@(posedge clk) disable iff (rst)
    word != '0)
    else $error("Generator word became zero.");

  a_rem_below_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_HOLD) |-> (bnd != '0 && rem < bnd))
    else $error("Partial remainder is not below the bound.");

  a_bad_means_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.bad_bound) |-> (rsp.value == '0))
    else $error("Bad-bound response carries a nonzero value.");

  a_div_then_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == CNT_W'(WORD_W - 1)) |=> (state == ST_HOLD))
    else $error("Remainder sequence did not end after all bits.");
`endif

endmodule
